[rtl/bra_pkg.sv]
package bra_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int MAX_BURST = 64;
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int BURST_W = 7;
   localparam int DATA_W = 8;
   localparam int REQ_W = 3;

   // The queue depth must be a power of two so that its pointers wrap by themselves.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [REQ_W-1:0] REQ_PUSH_BEGIN = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_BYTE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP = 3'd2;
   localparam logic [REQ_W-1:0] REQ_PEEK = 3'd3;
   localparam logic [REQ_W-1:0] REQ_DISCARD = 3'd4;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [BURST_W-1:0] byte_count;
      logic [DATA_W-1:0]  push_data;
   } req_item_type;

   typedef struct packed {
      logic [DATA_W-1:0]  read_data;
      logic               data_valid;
      logic               last_result;
      logic               accepted;
      logic [BURST_W-1:0] moved_count;
      logic [CNT_W-1:0]   bytes_held;
      logic [CNT_W-1:0]   space_free;
   } rsp_item_type;

   typedef enum logic [1:0] {
      CMD_PLAIN,
      CMD_WRITE,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [ADDR_W-1:0]  addr;
      logic [DATA_W-1:0]  data;
      logic [BURST_W-1:0] count;
      logic               accepted;
      logic [BURST_W-1:0] moved;
      logic [CNT_W-1:0]   held;
      logic [CNT_W-1:0]   space;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Pointer advance by at most the capacity; one subtraction is enough.
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] p,
                                                  input logic [CNT_W-1:0] n,
                                                  input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(p) + (CNT_W + 1)'(n);
      if (s >= (CNT_W + 1)'(cap)) begin
         s = s - (CNT_W + 1)'(cap);
      end
      return s[ADDR_W-1:0];
   endfunction

endpackage

[rtl/bra_ram.sv]
module bra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bra_queue.sv]
module bra_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bra_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output bra_pkg::cmd_type      head,
   output bra_pkg::q_status_type status
);

   bra_pkg::cmd_type                entries_ff [bra_pkg::QUEUE_DEPTH];
   logic [bra_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [bra_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [bra_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [bra_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [bra_pkg::QCNT_W-1:0]      count_ff;
   logic [bra_pkg::QCNT_W-1:0]      count_in;

   always_comb begin
      wr_ptr_in = push ? bra_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? bra_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = bra_pkg::QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = bra_pkg::QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head = entries_ff[rd_ptr_ff];
   assign status.full = (count_ff == bra_pkg::QCNT_W'(bra_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[rtl/bra_front.sv]
module bra_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  bra_pkg::req_item_type      req,
   input  logic                       csr_wr_en,
   input  logic [bra_pkg::CNT_W-1:0]  csr_wr_data,
   output logic                       cmd_push,
   output bra_pkg::cmd_type           cmd,
   output logic [bra_pkg::CNT_W-1:0]  capacity
);

   logic [bra_pkg::CNT_W-1:0]   cap_ff;
   logic [bra_pkg::CNT_W-1:0]   cap_in;
   logic [bra_pkg::ADDR_W-1:0]  wp_ff;
   logic [bra_pkg::ADDR_W-1:0]  wp_in;
   logic [bra_pkg::ADDR_W-1:0]  rp_ff;
   logic [bra_pkg::ADDR_W-1:0]  rp_in;
   logic [bra_pkg::CNT_W-1:0]   held_ff;
   logic [bra_pkg::CNT_W-1:0]   held_in;
   logic [bra_pkg::BURST_W-1:0] burst_ff;
   logic [bra_pkg::BURST_W-1:0] burst_in;
   logic [bra_pkg::CNT_W-1:0]   space;
   logic [bra_pkg::BURST_W-1:0] clipped;
   logic [bra_pkg::BURST_W-1:0] take;
   logic                        fits;

   always_comb begin
      cap_in = cap_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      held_in = held_ff;
      burst_in = burst_ff;
      cmd = '0;
      cmd.kind = bra_pkg::CMD_PLAIN;
      cmd_push = accept;
      space = cap_ff - held_ff;
      clipped = (req.byte_count > bra_pkg::BURST_W'(bra_pkg::MAX_BURST)) ?
                bra_pkg::BURST_W'(bra_pkg::MAX_BURST) : req.byte_count;
      take = (bra_pkg::CNT_W'(clipped) < held_ff) ? clipped : held_ff[bra_pkg::BURST_W-1:0];
      fits = 1'b0;

      if (accept) begin
         unique case (req.req_type) inside
            bra_pkg::REQ_PUSH_BEGIN: begin
               fits = (req.byte_count <= bra_pkg::BURST_W'(bra_pkg::MAX_BURST)) &&
                      (bra_pkg::CNT_W'(req.byte_count) <= space);
               if (fits) begin
                  burst_in = req.byte_count;
                  cmd.moved = req.byte_count;
               end
               cmd.accepted = fits;
            end
            bra_pkg::REQ_PUSH_BYTE: begin
               fits = (burst_ff != '0) && (held_ff < cap_ff);
               if (fits) begin
                  cmd.kind = bra_pkg::CMD_WRITE;
                  cmd.addr = wp_ff;
                  cmd.data = req.push_data;
                  cmd.moved = bra_pkg::BURST_W'(1);
                  wp_in = bra_pkg::wrap_add(wp_ff, bra_pkg::CNT_W'(1), cap_ff);
                  held_in = bra_pkg::CNT_W'(held_ff + 1'b1);
                  burst_in = bra_pkg::BURST_W'(burst_ff - 1'b1);
               end
               cmd.accepted = fits;
            end
            bra_pkg::REQ_POP, bra_pkg::REQ_PEEK, bra_pkg::REQ_DISCARD: begin
               cmd.moved = take;
               cmd.count = take;
               cmd.addr = rp_ff;
               if (req.req_type != bra_pkg::REQ_DISCARD && take != '0) begin
                  cmd.kind = bra_pkg::CMD_READ;
               end
               if (req.req_type != bra_pkg::REQ_PEEK) begin
                  rp_in = bra_pkg::wrap_add(rp_ff, bra_pkg::CNT_W'(take), cap_ff);
                  held_in = held_ff - bra_pkg::CNT_W'(take);
               end
            end
            default: begin
            end
         endcase
      end
      cmd.held = held_in;
      cmd.space = cap_ff - held_in;

      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            cap_in = bra_pkg::CNT_W'(1);
         end else if (csr_wr_data > bra_pkg::CNT_W'(bra_pkg::STORE_DEPTH)) begin
            cap_in = bra_pkg::CNT_W'(bra_pkg::STORE_DEPTH);
         end else begin
            cap_in = csr_wr_data;
         end
         wp_in = '0;
         rp_in = '0;
         held_in = '0;
         burst_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= bra_pkg::CNT_W'(bra_pkg::STORE_DEPTH);
         wp_ff <= '0;
         rp_ff <= '0;
         held_ff <= '0;
         burst_ff <= '0;
      end else begin
         cap_ff <= cap_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         held_ff <= held_in;
         burst_ff <= burst_in;
      end
   end

   assign capacity = cap_ff;

   held_within_capacity: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cap_ff)
      else $error("held byte count exceeds capacity");

   pointers_within_capacity: assert property (@(posedge clock) disable iff (reset)
      bra_pkg::CNT_W'(wp_ff) < cap_ff && bra_pkg::CNT_W'(rp_ff) < cap_ff)
      else $error("buffer pointer beyond capacity");

   push_grows_held: assert property (@(posedge clock) disable iff (reset)
      (cmd_push && cmd.kind == bra_pkg::CMD_WRITE && !csr_wr_en) |=>
      held_ff == bra_pkg::CNT_W'($past(held_ff) + 1'b1))
      else $error("stored byte not counted as held");

endmodule

[rtl/bra_back.sv]
module bra_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bra_pkg::cmd_type            head,
   input  bra_pkg::q_status_type       q_status,
   input  logic [bra_pkg::CNT_W-1:0]   capacity,
   output logic                        pop,
   output logic                        ram_wr_en,
   output logic [bra_pkg::ADDR_W-1:0]  ram_wr_addr,
   output logic [bra_pkg::DATA_W-1:0]  ram_wr_data,
   output logic                        ram_rd_en,
   output logic [bra_pkg::ADDR_W-1:0]  ram_rd_addr,
   input  logic [bra_pkg::DATA_W-1:0]  ram_rd_data,
   output logic                        rsp_strobe,
   output bra_pkg::rsp_item_type       rsp_item
);

   logic [bra_pkg::BURST_W-1:0] idx_ff;
   logic [bra_pkg::BURST_W-1:0] idx_in;
   logic [bra_pkg::ADDR_W-1:0]  ptr_ff;
   logic [bra_pkg::ADDR_W-1:0]  ptr_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   bra_pkg::rsp_item_type       out_ff;
   bra_pkg::rsp_item_type       out_in;
   logic [bra_pkg::ADDR_W-1:0]  cur_addr;
   logic                        go;
   logic                        last;
   logic                        is_read;

   always_comb begin
      go = !q_status.empty;
      is_read = (head.kind == bra_pkg::CMD_READ);
      cur_addr = (idx_ff == '0) ? head.addr : ptr_ff;
      last = !is_read || (bra_pkg::BURST_W'(idx_ff + 1'b1) == head.count);
      pop = go && last;

      ram_wr_en = go && (head.kind == bra_pkg::CMD_WRITE);
      ram_wr_addr = head.addr;
      ram_wr_data = head.data;
      ram_rd_en = go && is_read;
      ram_rd_addr = cur_addr;

      idx_in = idx_ff;
      ptr_in = ptr_ff;
      if (go) begin
         idx_in = last ? '0 : bra_pkg::BURST_W'(idx_ff + 1'b1);
         ptr_in = bra_pkg::wrap_add(cur_addr, bra_pkg::CNT_W'(1), capacity);
      end

      out_valid_in = go;
      out_in.read_data = '0;
      out_in.data_valid = is_read;
      out_in.last_result = last;
      out_in.accepted = head.accepted;
      out_in.moved_count = head.moved;
      out_in.bytes_held = head.held;
      out_in.space_free = head.space;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      ptr_ff <= ptr_in;
      out_ff <= out_in;
   end

   always_comb begin
      rsp_item = out_ff;
      rsp_item.read_data = out_ff.data_valid ? ram_rd_data : '0;
   end

   assign rsp_strobe = out_valid_ff;

   read_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (go && is_read) |-> head.count != '0)
      else $error("read command with no bytes");

   index_stays_in_burst: assert property (@(posedge clock) disable iff (reset)
      (go && is_read) |-> idx_ff < head.count)
      else $error("read index beyond burst length");

   last_closes_burst: assert property (@(posedge clock) disable iff (reset)
      (go && last) |=> idx_ff == '0)
      else $error("burst index not cleared after last result");

endmodule

[rtl/byte_ring_buffer_fifo.sv]
// The first result of a transaction is registered in the back end once its command is at the queue head.
// Push and discard transactions give one result each and are taken one per cycle while busy is low.
// A pop or peek of n bytes gives n results in the back end, one byte per cycle;
// busy is high while the two-entry command queue between front and back is full.
// Synchronous reset empties the buffer and sets the capacity to 1024; storage is not cleared.
// A capacity write also empties the buffer. Results cannot be stalled by the receiver.
module byte_ring_buffer_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  bra_pkg::req_item_type      req_item,
   output logic                       rsp_strobe,
   output bra_pkg::rsp_item_type      rsp_item,
   input  logic                       csr_wr_en,
   input  logic [bra_pkg::CNT_W-1:0]  csr_wr_data
);

   logic                        accept;
   logic                        cmd_push;
   bra_pkg::cmd_type            cmd;
   bra_pkg::cmd_type            head;
   bra_pkg::q_status_type       q_status;
   logic                        q_pop;
   logic [bra_pkg::CNT_W-1:0]   capacity;
   logic                        ram_wr_en;
   logic [bra_pkg::ADDR_W-1:0]  ram_wr_addr;
   logic [bra_pkg::DATA_W-1:0]  ram_wr_data;
   logic                        ram_rd_en;
   logic [bra_pkg::ADDR_W-1:0]  ram_rd_addr;
   logic [bra_pkg::DATA_W-1:0]  ram_rd_data;

   assign busy = q_status.full;
   assign accept = start && !q_status.full;

   bra_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_push    (cmd_push),
      .cmd         (cmd),
      .capacity    (capacity)
   );

   bra_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .pop      (q_pop),
      .head     (head),
      .status   (q_status)
   );

   bra_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .capacity    (capacity),
      .pop         (q_pop),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

   bra_ram #(
      .WIDTH (bra_pkg::DATA_W),
      .DEPTH (bra_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

[tb/byte_fifo_checker.sv]
module byte_fifo_checker
   import bra_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_item_type req_item,
   input  logic         rsp_strobe,
   input  rsp_item_type rsp_item,
   input  logic         csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   output int           mismatch_count,
   output int           pending_count
);

   logic [DATA_W-1:0] byte_mem [STORE_DEPTH];
   int unsigned wr_pos;
   int unsigned rd_pos;
   int unsigned held;
   int unsigned burst_left;
   int unsigned cap;
   rsp_item_type pending_rsp_q[$];

   initial begin
      mismatch_count = 0;
      pending_count = 0;
   end

   function automatic int unsigned ring_step(input int unsigned pos, input int unsigned n);
      int unsigned s;
      s = pos + n;
      if (s >= cap) begin
         s = s - cap;
      end
      return s;
   endfunction

   task automatic expect_rsp(input logic [DATA_W-1:0] data, input logic valid,
                             input logic last, input logic acc, input int unsigned moved);
      rsp_item_type r;
      r.read_data = data;
      r.data_valid = valid;
      r.last_result = last;
      r.accepted = acc;
      r.moved_count = moved[BURST_W-1:0];
      r.bytes_held = held[CNT_W-1:0];
      r.space_free = CNT_W'(cap - held);
      pending_rsp_q.push_back(r);
   endtask

   task automatic empty_ring();
      wr_pos = 0;
      rd_pos = 0;
      held = 0;
      burst_left = 0;
   endtask

   task automatic model_request(input req_item_type it);
      int unsigned n;
      int unsigned p;
      case (it.req_type)
         REQ_PUSH_BEGIN: begin
            if (it.byte_count <= MAX_BURST && it.byte_count <= cap - held) begin
               burst_left = it.byte_count;
               expect_rsp('0, 1'b0, 1'b1, 1'b1, it.byte_count);
            end else begin
               expect_rsp('0, 1'b0, 1'b1, 1'b0, 0);
            end
         end
         REQ_PUSH_BYTE: begin
            if (burst_left > 0 && held < cap) begin
               byte_mem[wr_pos] = it.push_data;
               wr_pos = ring_step(wr_pos, 1);
               held++;
               burst_left--;
               expect_rsp('0, 1'b0, 1'b1, 1'b1, 1);
            end else begin
               expect_rsp('0, 1'b0, 1'b1, 1'b0, 0);
            end
         end
         REQ_POP, REQ_PEEK, REQ_DISCARD: begin
            n = (it.byte_count > MAX_BURST) ? MAX_BURST : it.byte_count;
            if (n > held) begin
               n = held;
            end
            if (it.req_type == REQ_DISCARD || n == 0) begin
               if (it.req_type != REQ_PEEK) begin
                  rd_pos = ring_step(rd_pos, n);
                  held -= n;
               end
               expect_rsp('0, 1'b0, 1'b1, 1'b0, n);
            end else begin
               if (it.req_type == REQ_POP) begin
                  held -= n;
               end
               p = rd_pos;
               for (int i = 0; i < n; i++) begin
                  expect_rsp(byte_mem[p], 1'b1, i == n - 1, 1'b0, n);
                  p = ring_step(p, 1);
               end
               if (it.req_type == REQ_POP) begin
                  rd_pos = p;
               end
            end
         end
         default: begin
            expect_rsp('0, 1'b0, 1'b1, 1'b0, 0);
         end
      endcase
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      int unsigned v;
      if (reset) begin
         cap = STORE_DEPTH;
         empty_ring();
         pending_rsp_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_rsp_q.size() == 0) begin
               $error("Result transaction arrived with nothing expected.");
               mismatch_count++;
            end else begin
               want = pending_rsp_q.pop_front();
               check_field("read_data", want.read_data, rsp_item.read_data);
               check_field("data_valid", want.data_valid, rsp_item.data_valid);
               check_field("last_result", want.last_result, rsp_item.last_result);
               check_field("accepted", want.accepted, rsp_item.accepted);
               check_field("moved_count", want.moved_count, rsp_item.moved_count);
               check_field("bytes_held", want.bytes_held, rsp_item.bytes_held);
               check_field("space_free", want.space_free, rsp_item.space_free);
            end
         end
         if (csr_wr_en) begin
            v = csr_wr_data;
            if (v < 1) begin
               v = 1;
            end
            if (v > STORE_DEPTH) begin
               v = STORE_DEPTH;
            end
            cap = v;
            empty_ring();
         end
         if (start && !busy) begin
            model_request(req_item);
         end
      end
      pending_count <= pending_rsp_q.size();
   end

endmodule

[tb/tb_byte_ring_buffer_fifo.sv]
module tb_byte_ring_buffer_fifo;
   import bra_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_W'(REQ_DISCARD + 1);
   localparam logic [REQ_W-1:0] REQ_UNUSED_HI = '1;
   localparam int PHASES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_item_type req_item = '0;
   logic rsp_strobe;
   rsp_item_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;
   int mismatch_count;
   int pending_count;

   int cap_values [PHASES] = '{1024, 1, 0, 2, 7, 2047, 1025, 64, 100, 1024};
   int burst_lims [PHASES] = '{12, 1, 1, 2, 5, 12, 12, 12, 12, 12};
   int targets [PHASES] = '{40, 24, 16, 24, 32, 32, 24, 40, 48, 40};

   byte_ring_buffer_fifo dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   byte_fifo_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send(input logic [REQ_W-1:0] kind, input int count, input int data,
                       input bit idle_on);
      req_item_type it;
      it.req_type = kind;
      it.byte_count = count[BURST_W-1:0];
      it.push_data = data[DATA_W-1:0];
      if (idle_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input int value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[CNT_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int rand_count();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         return $urandom_range(0, 16);
      end else if (pick < 9) begin
         return $urandom_range(0, MAX_BURST);
      end
      return $urandom_range(MAX_BURST + 1, (1 << BURST_W) - 1);
   endfunction

   task automatic directed_checks();
      send(REQ_POP, 0, 0, 1'b0);
      send(REQ_PEEK, 5, 0, 1'b0);
      send(REQ_DISCARD, 3, 0, 1'b0);
      send(REQ_PUSH_BYTE, 0, 8'hFF, 1'b0);
      send(REQ_PUSH_BEGIN, MAX_BURST, 0, 1'b0);
      send(REQ_PUSH_BYTE, 0, 8'h00, 1'b0);
      send(REQ_PUSH_BYTE, 127, 8'hFF, 1'b0);
      send(REQ_PUSH_BYTE, 0, 8'hA5, 1'b0);
      send(REQ_PUSH_BYTE, 0, 8'h5A, 1'b0);
      send(REQ_PUSH_BEGIN, 0, 0, 1'b0);
      send(REQ_PUSH_BYTE, 0, 8'h12, 1'b0);
      send(REQ_PUSH_BEGIN, 127, 0, 1'b0);
      send(REQ_PUSH_BEGIN, MAX_BURST + 1, 0, 1'b0);
      send(REQ_PUSH_BEGIN, 3, 0, 1'b0);
      send(REQ_PUSH_BYTE, 0, 8'h81, 1'b0);
      send(REQ_PUSH_BEGIN, 2, 0, 1'b0);
      send(REQ_PUSH_BYTE, 0, 8'h7E, 1'b0);
      send(REQ_PUSH_BYTE, 0, 8'h01, 1'b0);
      send(REQ_PUSH_BYTE, 0, 8'h02, 1'b0);
      send(REQ_PEEK, 127, 0, 1'b0);
      send(REQ_POP, 2, 0, 1'b0);
      send(REQ_DISCARD, 1, 0, 1'b0);
      send(REQ_UNUSED_LO, 9, 8'h33, 1'b0);
      send(REQ_UNUSED_HI, 127, 8'hCC, 1'b0);
      send(REQ_POP, MAX_BURST, 0, 1'b0);
   endtask

   task automatic random_phase(input int target, input int burst_lim, input bit idle_on);
      int sent;
      int k;
      int nbytes;
      int pick;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            if ($urandom_range(0, 19) == 0) begin
               k = $urandom_range(MAX_BURST + 1, (1 << BURST_W) - 1);
               nbytes = $urandom_range(0, 2);
            end else begin
               k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_BURST)
                                                : $urandom_range(1, burst_lim);
               nbytes = k;
               if ($urandom_range(0, 7) == 0) begin
                  nbytes = k + 1;
               end else if (k > 0 && $urandom_range(0, 7) == 0) begin
                  nbytes = k - 1;
               end
            end
            send(REQ_PUSH_BEGIN, k, $urandom, idle_on);
            sent++;
            repeat (nbytes) begin
               send(REQ_PUSH_BYTE, $urandom, $urandom, idle_on);
               sent++;
            end
         end else if (pick < 75) begin
            send(REQ_POP, rand_count(), $urandom, idle_on);
            sent++;
         end else if (pick < 87) begin
            send(REQ_PEEK, rand_count(), $urandom, idle_on);
            sent++;
         end else if (pick < 94) begin
            send(REQ_DISCARD, rand_count(), $urandom, idle_on);
            sent++;
         end else if (pick < 97) begin
            send(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)), $urandom, $urandom,
                 idle_on);
            sent++;
         end else if (pick < 99) begin
            send(REQ_PUSH_BYTE, $urandom, $urandom, idle_on);
            sent++;
         end else begin
            send(REQ_PUSH_BEGIN, 0, $urandom, idle_on);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_checks();
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         write_capacity(cap_values[ph]);
         random_phase(targets[ph], burst_lims[ph],
                      ph < PHASES - 2 && $urandom_range(0, 2) != 0);
      end
      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
